### sv/interrupt_status_mask_regs_core_macros.svh
// Assertion macros shared by the interrupt status/mask register block.
`ifndef INTERRUPT_STATUS_MASK_REGS_CORE_MACROS_SVH
`define INTERRUPT_STATUS_MASK_REGS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, switched off while reset is held.
`define ISMR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold during reset as well.
`define ISMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ISMR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISMR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/ismr_pkg.sv
// Types, codes and window addresses for the interrupt status/mask registers.
package ismr_pkg;

    localparam logic [31:0] STATUS_ADDR  = 32'd528486512;
    localparam logic [31:0] MASK_ADDR    = 32'd528486516;
    localparam logic [31:0] CONTROL_ADDR = 32'd528486520;

    localparam logic [31:0] WINDOW_BYTES = 32'd4;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Largest byte offset a halfword may start at inside a window.
    localparam logic [1:0] HALF_MAX_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        WIN_STATUS,
        WIN_MASK,
        WIN_CONTROL
    } win_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [5:0]  irq_number;
    } req_word_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
    } rsp_word_t;

    // Decode outcome for a bus access.
    typedef struct packed {
        logic       access_ok;
        win_t       win;
        logic [1:0] offset;
    } dec_t;

endpackage

### sv/interrupt_status_mask_regs_core.sv
// Interrupt status/mask/control registers behind a request/response word interface.
//
// Each request word is a bus read, a bus write or an interrupt raise, and gives exactly
// one response word in the cycle after it is accepted. The decode, the lane masking and
// the register update are one level of logic between the request handshake and the
// response register, so a new request is taken in every cycle while the response
// register is empty or being drained; only a stalled response holds requests back.
// Reading the control register clears it; a status write acknowledges pending bits by
// clearing the lanes where the written data is zero; raises of source 32 or above are
// ignored but still answer ok.
module interrupt_status_mask_regs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ismr_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ismr_pkg::rsp_word_t rsp
);
    import ismr_pkg::*;
    `include "interrupt_status_mask_regs_core_macros.svh"

    logic [31:0] status_reg;
    logic [31:0] status_next;
    logic [31:0] mask_reg;
    logic [31:0] mask_next;
    logic [31:0] control_reg;
    logic [31:0] control_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rsp_word_t   rsp_reg;
    rsp_word_t   rsp_next;

    dec_t        dec;
    logic        accept;
    logic [4:0]  shift;
    logic [31:0] size_mask;
    logic [31:0] lanes;
    logic [31:0] shifted;
    logic [31:0] sel_reg;

    ismr_decode u_decode (
        .req (req),
        .dec (dec)
    );

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign shift = {dec.offset, 3'b000};

    always_comb
    begin
        unique case (req.access_size)
            SIZE_BYTE: size_mask = 32'h0000_00FF;
            SIZE_HALF: size_mask = 32'h0000_FFFF;
            default:   size_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign lanes   = size_mask << shift;
    assign shifted = (req.write_data << shift) & lanes;

    always_comb
    begin
        unique case (dec.win)
            WIN_STATUS:  sel_reg = status_reg;
            WIN_MASK:    sel_reg = mask_reg;
            WIN_CONTROL: sel_reg = control_reg;
            default:     sel_reg = '0;
        endcase
    end

    always_comb
    begin
        status_next    = status_reg;
        mask_next      = mask_reg;
        control_next   = control_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.ok        = 1'b0;
            rsp_next.read_data = '0;
            if (req.cmd == CMD_RAISE)
            begin
                rsp_next.ok = 1'b1;
                if (!req.irq_number[5])
                begin
                    status_next = status_reg | (32'd1 << req.irq_number[4:0]);
                end
            end
            else if (dec.access_ok)
            begin
                rsp_next.ok = 1'b1;
                if (req.cmd == CMD_READ)
                begin
                    rsp_next.read_data = (sel_reg >> shift) & size_mask;
                    if (dec.win == WIN_CONTROL)
                    begin
                        control_next = '0;
                    end
                end
                else
                begin
                    unique case (dec.win)
                        WIN_STATUS:  status_next  = status_reg & (~lanes | shifted);
                        WIN_MASK:    mask_next    = (mask_reg & ~lanes) | shifted;
                        WIN_CONTROL: control_next = (control_reg & ~lanes) | shifted;
                        default:     control_next = control_reg;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= '0;
            mask_reg      <= '0;
            control_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            mask_reg      <= mask_next;
            control_reg   <= control_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // A raise of a source below 32 leaves its status bit set.
    `ISMR_ASSERT(a_raise_sets, clk, rst_n, accept && (req.cmd == CMD_RAISE) && !req.irq_number[5] |=> status_reg[$past(req.irq_number[4:0])], "raise did not set status bit")

    // A successful control read leaves control cleared.
    `ISMR_ASSERT(a_ctrl_read_clears, clk, rst_n, accept && (req.cmd == CMD_READ) && dec.access_ok && (dec.win == WIN_CONTROL) |=> (control_reg == '0), "control read did not clear")

    // A failed access never returns data.
    `ISMR_ASSERT(a_fail_zero, clk, rst_n, rsp_valid && !rsp.ok |-> (rsp.read_data == '0), "failed access returned data")

    // Requests are only held back by a waiting response.
    `ISMR_ASSERT_ALWAYS(a_ready_when_empty, clk, !rsp_valid |-> req_ready, "request stalled with empty response register")

endmodule

### sv/ismr_decode.sv
// Address window decode and alignment check for one bus access.
module ismr_decode (
    input  ismr_pkg::req_word_t req,
    output ismr_pkg::dec_t      dec
);
    import ismr_pkg::*;

    logic [31:0] d_status;
    logic [31:0] d_mask;
    logic [31:0] d_control;
    logic        hit_status;
    logic        hit_mask;
    logic        hit_control;
    logic        is_access;
    logic        aligned;
    win_t        win_sel;
    logic [1:0]  off_sel;

    assign d_status  = req.address - STATUS_ADDR;
    assign d_mask    = req.address - MASK_ADDR;
    assign d_control = req.address - CONTROL_ADDR;

    // A window never wraps past the top of the address space.
    assign hit_status  = (req.address >= STATUS_ADDR) && (d_status < WINDOW_BYTES);
    assign hit_mask    = (req.address >= MASK_ADDR) && (d_mask < WINDOW_BYTES);
    assign hit_control = (req.address >= CONTROL_ADDR) && (d_control < WINDOW_BYTES);

    assign is_access = ((req.cmd == CMD_READ) || (req.cmd == CMD_WRITE)) &&
                       ((req.access_size == SIZE_BYTE) || (req.access_size == SIZE_HALF) ||
                        (req.access_size == SIZE_WORD));

    always_comb
    begin
        win_sel = WIN_STATUS;
        off_sel = d_status[1:0];
        // Overlapping windows resolve in the order status, mask, control.
        priority if (hit_status)
        begin
            win_sel = WIN_STATUS;
            off_sel = d_status[1:0];
        end
        else if (hit_mask)
        begin
            win_sel = WIN_MASK;
            off_sel = d_mask[1:0];
        end
        else if (hit_control)
        begin
            win_sel = WIN_CONTROL;
            off_sel = d_control[1:0];
        end
        else
        begin
            win_sel = WIN_STATUS;
            off_sel = d_status[1:0];
        end
    end

    always_comb
    begin
        unique case (req.access_size)
            SIZE_BYTE: aligned = 1'b1;
            SIZE_HALF: aligned = (off_sel <= HALF_MAX_OFFSET);
            SIZE_WORD: aligned = (off_sel == 2'd0);
            default:   aligned = 1'b0;
        endcase
    end

    assign dec = {is_access && aligned && (hit_status || hit_mask || hit_control),
                  win_sel, off_sel};

endmodule
